@@ design/irs_pkg.sv @@
// shared types, fixed-point widths, pipeline timing and multiply helpers
// for the inertial-to-rtn relative state block; no dependencies
`default_nettype none

package irs_pkg;

  // q31.32 word, exact product width, fraction bits
  localparam int QW = 64;
  localparam int FW = 32;
  localparam int PW = 2 * QW;
  // square-root remainder width
  localparam int RW = QW + 3;

  typedef logic signed [QW-1:0] q_t;
  typedef q_t [2:0] vec_t;
  typedef logic [3:0][QW-1:0] pp_t;

  localparam q_t Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam q_t Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef struct packed {
    q_t chief_pos_x;
    q_t chief_pos_y;
    q_t chief_pos_z;
    q_t chief_vel_x;
    q_t chief_vel_y;
    q_t chief_vel_z;
    q_t deputy_pos_x;
    q_t deputy_pos_y;
    q_t deputy_pos_z;
    q_t deputy_vel_x;
    q_t deputy_vel_y;
    q_t deputy_vel_z;
  } irs_in_t;

  typedef struct packed {
    q_t   rel_pos_radial;
    q_t   rel_pos_along;
    q_t   rel_pos_normal;
    q_t   rel_vel_radial;
    q_t   rel_vel_along;
    q_t   rel_vel_normal;
    logic degenerate;
  } irs_out_t;

  // unit latencies
  localparam int L_MUL      = 4;
  localparam int L_DOT      = L_MUL + 3;
  localparam int SQRT_STEPS = QW;
  localparam int L_NORM     = L_MUL + 1 + SQRT_STEPS;
  localparam int DIV_STEPS  = QW - 1;
  localparam int L_DIV      = DIV_STEPS + 3;

  // cycle offsets after the input register
  localparam int T_H   = L_DOT;
  localparam int T_RN  = L_NORM;
  localparam int T_HN  = T_H + L_NORM;
  localparam int T_UR  = T_RN + L_DIV;
  localparam int T_UN  = T_HN + L_DIV;
  localparam int T_W   = T_RN + 2 * L_DIV;
  localparam int T_UT  = T_UN + L_DOT;
  localparam int T_C   = T_W + L_DOT;
  localparam int T_DOT = T_C + 1;
  localparam int T_DEG = T_HN + 1;
  localparam int T_OUT = T_DOT + L_DOT + 1;

  // magnitude of a signed word, most negative value maps to 2^63
  function automatic logic [QW-1:0] mag64(q_t v);
    mag64 = v[QW-1] ? QW'(-v) : QW'(v);
  endfunction

  // four half-word partial products
  function automatic pp_t pp_mul(logic [QW-1:0] a, logic [QW-1:0] b);
    pp_t p;
    p[0] = a[FW-1:0] * b[FW-1:0];
    p[1] = a[FW-1:0] * b[QW-1:FW];
    p[2] = a[QW-1:FW] * b[FW-1:0];
    p[3] = a[QW-1:FW] * b[QW-1:FW];
    pp_mul = p;
  endfunction

  // combine partial products into the exact unsigned product
  function automatic logic [PW-1:0] pp_sum(pp_t p);
    pp_sum = {{QW{1'b0}}, p[0]} + {{FW{1'b0}}, p[1], {FW{1'b0}}}
           + {{FW{1'b0}}, p[2], {FW{1'b0}}} + {p[3], {QW{1'b0}}};
  endfunction

endpackage

`default_nettype wire

@@ design/irs_dot.sv @@
// pipelined three-term fixed-point dot product with exact products, saturating
// accumulation, round half up and saturation; term 1 may be negated for cross products; uses irs_pkg
`default_nettype none

module irs_dot (
  input  logic          clk,
  input  irs_pkg::vec_t a,
  input  irs_pkg::vec_t b,
  input  logic          sub1,
  output irs_pkg::q_t   y
);
  import irs_pkg::*;

  logic [2:0][QW-1:0] am_r, bm_r;
  logic [2:0]         neg1_r, neg2_r, neg3_r;
  pp_t  [2:0]         pp_r;
  logic [2:0][PW-1:0] mag_r;
  logic [PW-1:0]      prod_r [3];
  logic [PW-1:0]      s01_r, t2_r, s012_r;
  q_t                 y_r;

  // signed add saturating at the product width
  function automatic logic [PW-1:0] sat_add(logic [PW-1:0] x, logic [PW-1:0] z);
    logic [PW:0] s;
    s = {x[PW-1], x} + {z[PW-1], z};
    if (s[PW] != s[PW-1]) begin
      sat_add = s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end else begin
      sat_add = s[PW-1:0];
    end
  endfunction

  // drop fraction bits, round half up, saturate to a word
  function automatic q_t q_round(logic [PW-1:0] v);
    logic [QW-1:0]    mid;
    logic [PW-QW-FW-1:0] top;
    logic [QW-1:0]    rb;
    mid = v[QW+FW-1:FW];
    top = v[PW-1:QW+FW];
    rb  = {{(QW-1){1'b0}}, v[FW-1]};
    if (top == '0 && !mid[QW-1]) begin
      q_round = (mid == QW'(Q_MAX) && rb[0]) ? Q_MAX : q_t'(mid + rb);
    end else if (top == '1 && mid[QW-1]) begin
      q_round = q_t'(mid + rb);
    end else begin
      q_round = v[PW-1] ? Q_MIN : Q_MAX;
    end
  endfunction

  // magnitudes, partial products, exact products, signed products
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      am_r[k]   <= mag64(a[k]);
      bm_r[k]   <= mag64(b[k]);
      neg1_r[k] <= a[k][QW-1] ^ b[k][QW-1] ^ ((k == 1) && sub1);
      pp_r[k]   <= pp_mul(am_r[k], bm_r[k]);
      neg2_r[k] <= neg1_r[k];
      mag_r[k]  <= pp_sum(pp_r[k]);
      neg3_r[k] <= neg2_r[k];
      prod_r[k] <= neg3_r[k] ? -mag_r[k] : mag_r[k];
    end
  end

  // accumulate in order, then round
  always_ff @(posedge clk) begin
    s01_r  <= sat_add(prod_r[0], prod_r[1]);
    t2_r   <= prod_r[2];
    s012_r <= sat_add(s01_r, t2_r);
    y_r    <= q_round(s012_r);
  end

  assign y = y_r;

endmodule

`default_nettype wire

@@ design/irs_div.sv @@
// pipelined restoring divider: (n * 2^32) / d truncated toward zero and
// saturated, one quotient bit per stage; uses irs_pkg
`default_nettype none

module irs_div (
  input  logic                   clk,
  input  irs_pkg::q_t            n,
  input  logic [irs_pkg::QW-1:0] d,
  output irs_pkg::q_t            y
);
  import irs_pkg::*;

  logic [QW-1:0]        m_r, d1_r;
  logic                 s1_r;
  logic [QW:0]          rem_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] nlo_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] quo_r [DIV_STEPS+1];
  logic [QW-1:0]        dv_r  [DIV_STEPS+1];
  logic [DIV_STEPS:0]   ovf_r, sgn_r;
  q_t                   y_r;

  // magnitude, then overflow test and initial remainder
  always_ff @(posedge clk) begin
    m_r      <= mag64(n);
    d1_r     <= d;
    s1_r     <= n[QW-1];
    ovf_r[0] <= {{(FW-1){1'b0}}, m_r} >= {d1_r, {(FW-1){1'b0}}};
    sgn_r[0] <= s1_r;
    rem_r[0] <= (QW+1)'(m_r[QW-1:FW-1]);
    nlo_r[0] <= {m_r[FW-2:0], {FW{1'b0}}};
    quo_r[0] <= '0;
    dv_r[0]  <= d1_r;
  end

  // one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [QW:0] trial;
    assign trial = {rem_r[j][QW-1:0], nlo_r[j][DIV_STEPS-1]};
    always_ff @(posedge clk) begin
      if (trial >= {1'b0, dv_r[j]}) begin
        rem_r[j+1] <= trial - {1'b0, dv_r[j]};
        quo_r[j+1] <= {quo_r[j][DIV_STEPS-2:0], 1'b1};
      end else begin
        rem_r[j+1] <= trial;
        quo_r[j+1] <= {quo_r[j][DIV_STEPS-2:0], 1'b0};
      end
      nlo_r[j+1]   <= {nlo_r[j][DIV_STEPS-2:0], 1'b0};
      dv_r[j+1]    <= dv_r[j];
      ovf_r[j+1]   <= ovf_r[j];
      sgn_r[j+1]   <= sgn_r[j];
    end
  end

  // sign and saturation
  always_ff @(posedge clk) begin
    if (ovf_r[DIV_STEPS]) begin
      y_r <= sgn_r[DIV_STEPS] ? Q_MIN : Q_MAX;
    end else if (sgn_r[DIV_STEPS]) begin
      y_r <= -q_t'({1'b0, quo_r[DIV_STEPS]});
    end else begin
      y_r <= q_t'({1'b0, quo_r[DIV_STEPS]});
    end
  end

  assign y = y_r;

endmodule

`default_nettype wire

@@ design/inertial_to_rtn_relative_state.sv @@
// top level: chief/deputy inertial states to relative state in the chief rtn frame
// depends on irs_pkg, irs_dot, irs_div
//
//   channel   ports                       handshake
//   input     start, busy, in_data        accepted when start high and busy low
//   result    out_valid, out_data         one-cycle strobe, no back-pressure
//
// one item enters every cycle; busy is always low
// each result passes from its request through the norm of the chief position
// (64 one-bit square-root stages), two chained 63-stage dividers, cross
// product and the final dot products
// reset clears only the valid line; data registers carry no reset
`default_nettype none

module inertial_to_rtn_relative_state (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  irs_pkg::irs_in_t  in_data,
  output logic              out_valid,
  output irs_pkg::irs_out_t out_data
);
  import irs_pkg::*;

  localparam int D_RC  = T_RN;
  localparam int D_H   = T_HN - T_H;
  localparam int D_RN  = L_DIV;
  localparam int D_UR  = T_DOT - T_UR;
  localparam int D_UN  = T_DOT - T_UN;
  localparam int D_UT  = T_DOT - T_UT;
  localparam int D_DR  = T_DOT - 1;
  localparam int D_DV  = T_C - 1;
  localparam int D_DEG = T_DOT + L_DOT - T_DEG;

  irs_in_t  in_r;
  logic     v0_r;
  logic     vld_r [T_OUT];
  vec_t     rc, vc, rd, vd, h, ur, un, ut, w1, w, c, po, vo;
  vec_t     dr_r, dv_r, vr_r;
  vec_t     nin [2];
  logic [QW-1:0] nout [2];
  logic [QW-1:0] rn, hn;
  logic     deg_r;
  irs_out_t out_nxt, out_r;

  vec_t          rc_dly_r [D_RC];
  vec_t          h_dly_r  [D_H];
  logic [QW-1:0] rn_dly_r [D_RN];
  vec_t          ur_dly_r [D_UR];
  vec_t          un_dly_r [D_UN];
  vec_t          ut_dly_r [D_UT];
  vec_t          dr_dly_r [D_DR];
  vec_t          dv_dly_r [D_DV];
  logic          deg_dly_r [D_DEG];
  vec_t          ax [3];

  // saturating word subtract
  function automatic q_t ssub(q_t a, q_t b);
    logic [QW:0] s;
    s = {a[QW-1], a} - {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      ssub = s[QW] ? Q_MIN : Q_MAX;
    end else begin
      ssub = s[QW-1:0];
    end
  endfunction

  assign busy = 1'b0;

  // input register and valid line
  always_ff @(posedge clk) begin
    in_r <= in_data;
    if (!rst_n) begin
      v0_r <= 1'b0;
      for (int i = 0; i < T_OUT; i++) vld_r[i] <= 1'b0;
    end else begin
      v0_r     <= start && !busy;
      vld_r[0] <= v0_r;
      for (int i = 1; i < T_OUT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign rc = {in_r.chief_pos_z, in_r.chief_pos_y, in_r.chief_pos_x};
  assign vc = {in_r.chief_vel_z, in_r.chief_vel_y, in_r.chief_vel_x};
  assign rd = {in_r.deputy_pos_z, in_r.deputy_pos_y, in_r.deputy_pos_x};
  assign vd = {in_r.deputy_vel_z, in_r.deputy_vel_y, in_r.deputy_vel_x};

  // relative position and velocity in the inertial frame
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      dr_r[k] <= ssub(rd[k], rc[k]);
      dv_r[k] <= ssub(vd[k], vc[k]);
    end
  end

  // cross products: h = rc x vc, ut = un x ur, c = w x dr
  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int I = (k + 1) % 3;
    localparam int J = (k + 2) % 3;
    vec_t urt, drt;
    assign urt = ur_dly_r[T_UN-T_UR-1];
    assign drt = dr_dly_r[T_W-2];
    irs_dot u_h (
      .clk (clk), .a({q_t'(0), rc[J], rc[I]}), .b({q_t'(0), vc[I], vc[J]}),
      .sub1(1'b1), .y(h[k])
    );
    irs_dot u_ut (
      .clk (clk), .a({q_t'(0), un[J], un[I]}), .b({q_t'(0), urt[I], urt[J]}),
      .sub1(1'b1), .y(ut[k])
    );
    irs_dot u_c (
      .clk (clk), .a({q_t'(0), w[J], w[I]}), .b({q_t'(0), drt[I], drt[J]}),
      .sub1(1'b1), .y(c[k])
    );
  end

  // norms of rc and h: squares, sum, one root bit per stage
  assign nin[0] = rc;
  assign nin[1] = h;

  for (genvar g = 0; g < 2; g++) begin : g_norm
    logic [2:0][QW-1:0] sa_r;
    pp_t  [2:0]         sp_r;
    logic [2:0][PW-1:0] sq_r;
    logic [PW-1:0]      s01_r, s2_r, rad0_r;
    logic [QW-1:0]      rt_r [SQRT_STEPS];
    logic [RW-1:0]      rm_r [SQRT_STEPS];
    logic [PW-1:0]      rd_r [SQRT_STEPS];

    always_ff @(posedge clk) begin
      for (int k = 0; k < 3; k++) begin
        sa_r[k] <= mag64(nin[g][k]);
        sp_r[k] <= pp_mul(sa_r[k], sa_r[k]);
        sq_r[k] <= pp_sum(sp_r[k]);
      end
      s01_r  <= sq_r[0] + sq_r[1];
      s2_r   <= sq_r[2];
      rad0_r <= s01_r + s2_r;
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
      logic [QW-1:0] rt_in;
      logic [RW-1:0] rm_in, cur, trial;
      logic [PW-1:0] rd_in;
      if (j == 0) begin : g_first
        assign rt_in = '0;
        assign rm_in = '0;
        assign rd_in = rad0_r;
      end else begin : g_next
        assign rt_in = rt_r[j-1];
        assign rm_in = rm_r[j-1];
        assign rd_in = rd_r[j-1];
      end
      assign cur   = {rm_in[RW-3:0], rd_in[PW-1 -: 2]};
      assign trial = {1'b0, rt_in, 2'b01};
      always_ff @(posedge clk) begin
        if (cur >= trial) begin
          rm_r[j] <= cur - trial;
          rt_r[j] <= {rt_in[QW-2:0], 1'b1};
        end else begin
          rm_r[j] <= cur;
          rt_r[j] <= {rt_in[QW-2:0], 1'b0};
        end
        rd_r[j] <= {rd_in[PW-3:0], 2'b00};
      end
    end

    // clamp to the largest positive word
    assign nout[g] = rt_r[SQRT_STEPS-1][QW-1] ? QW'(Q_MAX) : rt_r[SQRT_STEPS-1];
  end

  assign rn = nout[0];
  assign hn = nout[1];

  // unit vectors and angular velocity h / |rc|^2
  for (genvar k = 0; k < 3; k++) begin : g_div
    irs_div u_ur (.clk(clk), .n(rc_dly_r[D_RC-1][k]), .d(rn), .y(ur[k]));
    irs_div u_un (.clk(clk), .n(h_dly_r[T_HN-T_H-1][k]), .d(hn), .y(un[k]));
    irs_div u_w1 (.clk(clk), .n(h_dly_r[T_RN-T_H-1][k]), .d(rn), .y(w1[k]));
    irs_div u_w  (.clk(clk), .n(w1[k]), .d(rn_dly_r[D_RN-1]), .y(w[k]));
  end

  // degenerate geometry flag
  always_ff @(posedge clk) begin
    deg_r <= (rn_dly_r[T_HN-T_RN-1] == '0) || (hn == '0);
  end

  // rotating-frame velocity
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) vr_r[k] <= ssub(dv_dly_r[D_DV-1][k], c[k]);
  end

  // alignment delay lines
  always_ff @(posedge clk) begin
    rc_dly_r[0]  <= rc;
    h_dly_r[0]   <= h;
    rn_dly_r[0]  <= rn;
    ur_dly_r[0]  <= ur;
    un_dly_r[0]  <= un;
    ut_dly_r[0]  <= ut;
    dr_dly_r[0]  <= dr_r;
    dv_dly_r[0]  <= dv_r;
    deg_dly_r[0] <= deg_r;
    for (int i = 1; i < D_RC; i++)  rc_dly_r[i]  <= rc_dly_r[i-1];
    for (int i = 1; i < D_H; i++)   h_dly_r[i]   <= h_dly_r[i-1];
    for (int i = 1; i < D_RN; i++)  rn_dly_r[i]  <= rn_dly_r[i-1];
    for (int i = 1; i < D_UR; i++)  ur_dly_r[i]  <= ur_dly_r[i-1];
    for (int i = 1; i < D_UN; i++)  un_dly_r[i]  <= un_dly_r[i-1];
    for (int i = 1; i < D_UT; i++)  ut_dly_r[i]  <= ut_dly_r[i-1];
    for (int i = 1; i < D_DR; i++)  dr_dly_r[i]  <= dr_dly_r[i-1];
    for (int i = 1; i < D_DV; i++)  dv_dly_r[i]  <= dv_dly_r[i-1];
    for (int i = 1; i < D_DEG; i++) deg_dly_r[i] <= deg_dly_r[i-1];
  end

  // projections onto radial, along-track and normal axes
  assign ax[0] = ur_dly_r[D_UR-1];
  assign ax[1] = ut_dly_r[D_UT-1];
  assign ax[2] = un_dly_r[D_UN-1];

  for (genvar a = 0; a < 3; a++) begin : g_proj
    irs_dot u_pos (.clk(clk), .a(ax[a]), .b(dr_dly_r[D_DR-1]), .sub1(1'b0), .y(po[a]));
    irs_dot u_vel (.clk(clk), .a(ax[a]), .b(vr_r), .sub1(1'b0), .y(vo[a]));
  end

  // result register, zeroed on degenerate geometry
  always_comb begin
    out_nxt.rel_pos_radial = po[0];
    out_nxt.rel_pos_along  = po[1];
    out_nxt.rel_pos_normal = po[2];
    out_nxt.rel_vel_radial = vo[0];
    out_nxt.rel_vel_along  = vo[1];
    out_nxt.rel_vel_normal = vo[2];
    out_nxt.degenerate     = 1'b0;
    if (deg_dly_r[D_DEG-1]) begin
      out_nxt            = '0;
      out_nxt.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = vld_r[T_OUT-1];
  assign out_data  = out_r;

endmodule

`default_nettype wire

@@ verif/tb_inertial_to_rtn_relative_state.sv @@
// testbench for inertial_to_rtn_relative_state: directed table, then random state pairs
// depends on irs_pkg and the design top; predicts each untyped result with a bit-exact fixed-point model
`default_nettype none

module tb_inertial_to_rtn_relative_state;
  import irs_pkg::*;

  localparam int N_RANDOM = 650;
  localparam int DRAIN    = T_OUT + 40;
  localparam int LIMIT    = 400000;

  typedef logic signed [127:0] w_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  irs_in_t  in_data;
  logic     out_valid;
  irs_out_t out_data;

  irs_out_t rtn_expected[$];
  int       n_fail;
  int       n_checked;
  int       n_degen;
  int       cycles;

  inertial_to_rtn_relative_state i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- fixed-point predictor ----------------

  // 128-bit add saturating at the 128-bit range
  function automatic w_t acc_add(w_t a, w_t b);
    w_t s;
    s = a + b;
    if (a[127] == b[127] && s[127] != a[127])
      s = a[127] ? {1'b1, 127'd0} : {1'b0, {127{1'b1}}};
    return s;
  endfunction

  // q64 to q32, round half up, saturate
  function automatic q_t acc_round(w_t v);
    logic [63:0] mid;
    logic [31:0] top;
    logic        rb;
    mid = v[95:32];
    top = v[127:96];
    rb  = v[31];
    if (top == 32'd0 && !mid[63]) begin
      if (mid == Q_MAX && rb) return Q_MAX;
      return q_t'(mid + rb);
    end
    if (top == 32'hFFFF_FFFF && mid[63]) return q_t'(mid + rb);
    return v[127] ? Q_MIN : Q_MAX;
  endfunction

  function automatic w_t wide_mul(q_t a, q_t b);
    w_t wa, wb;
    wa = a;
    wb = b;
    return wa * wb;
  endfunction

  function automatic q_t cross_term(q_t a, q_t b, q_t c, q_t d);
    return acc_round(acc_add(wide_mul(a, b), -wide_mul(c, d)));
  endfunction

  function automatic q_t dot3(vec_t a, vec_t b);
    w_t s;
    s = wide_mul(a[0], b[0]);
    s = acc_add(s, wide_mul(a[1], b[1]));
    s = acc_add(s, wide_mul(a[2], b[2]));
    return acc_round(s);
  endfunction

  function automatic q_t sat_sub(q_t a, q_t b);
    q_t r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) return a[63] ? Q_MIN : Q_MAX;
    return r;
  endfunction

  function automatic logic [63:0] abs64(q_t v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // floor of the euclidean norm of the raw words, clamped
  function automatic logic [63:0] vec_norm(vec_t v);
    logic [127:0] s, p;
    logic [63:0]  r, c;
    s = 0;
    for (int i = 0; i < 3; i++) s += {64'd0, abs64(v[i])} * {64'd0, abs64(v[i])};
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      p = {64'd0, c} * {64'd0, c};
      if (p <= s) r = c;
    end
    return (r > Q_MAX) ? Q_MAX : r;
  endfunction

  // (n * 2^32) / d, truncated, saturated
  function automatic q_t fx_div(q_t n, logic [63:0] d);
    logic [63:0]  m;
    logic [127:0] q;
    m = abs64(n);
    if (d == 0) return 0;
    if (m / d >= 64'h8000_0000) return n[63] ? Q_MIN : Q_MAX;
    q = {32'd0, m, 32'd0} / {64'd0, d};
    return n[63] ? -q_t'(q[63:0]) : q_t'(q[63:0]);
  endfunction

  function automatic irs_out_t predict_rtn(irs_in_t x);
    vec_t rc, vc, rd, vd, h, ur, un, ut, dr, dv, w, c, vr;
    logic [63:0] rn, hn;
    irs_out_t o;
    rc = '{x.chief_pos_z, x.chief_pos_y, x.chief_pos_x};
    vc = '{x.chief_vel_z, x.chief_vel_y, x.chief_vel_x};
    rd = '{x.deputy_pos_z, x.deputy_pos_y, x.deputy_pos_x};
    vd = '{x.deputy_vel_z, x.deputy_vel_y, x.deputy_vel_x};
    h[0] = cross_term(rc[1], vc[2], rc[2], vc[1]);
    h[1] = cross_term(rc[2], vc[0], rc[0], vc[2]);
    h[2] = cross_term(rc[0], vc[1], rc[1], vc[0]);
    rn = vec_norm(rc);
    hn = vec_norm(h);
    o = '0;
    if (rn == 0 || hn == 0) begin
      o.degenerate = 1'b1;
      return o;
    end
    for (int i = 0; i < 3; i++) begin
      ur[i] = fx_div(rc[i], rn);
      un[i] = fx_div(h[i], hn);
      dr[i] = sat_sub(rd[i], rc[i]);
      dv[i] = sat_sub(vd[i], vc[i]);
      w[i]  = fx_div(fx_div(h[i], rn), rn);
    end
    ut[0] = cross_term(un[1], ur[2], un[2], ur[1]);
    ut[1] = cross_term(un[2], ur[0], un[0], ur[2]);
    ut[2] = cross_term(un[0], ur[1], un[1], ur[0]);
    c[0]  = cross_term(w[1], dr[2], w[2], dr[1]);
    c[1]  = cross_term(w[2], dr[0], w[0], dr[2]);
    c[2]  = cross_term(w[0], dr[1], w[1], dr[0]);
    for (int i = 0; i < 3; i++) vr[i] = sat_sub(dv[i], c[i]);
    o.rel_pos_radial = dot3(ur, dr);
    o.rel_pos_along  = dot3(ut, dr);
    o.rel_pos_normal = dot3(un, dr);
    o.rel_vel_radial = dot3(ur, vr);
    o.rel_vel_along  = dot3(ut, vr);
    o.rel_vel_normal = dot3(un, vr);
    return o;
  endfunction

  // ---------------- request tracking and result checking ----------------

  // typed-in expectation for the next accepted request, if any
  logic     use_typed;
  irs_out_t typed_exp;

  always @(posedge clk) begin
    if (rst_n && start && !busy)
      rtn_expected.push_back(use_typed ? typed_exp : predict_rtn(in_data));
  end

  always @(posedge clk) begin
    irs_out_t e;
    if (rst_n && out_valid) begin
      if (rtn_expected.size() == 0) begin
        $error("result with no pending request");
        n_fail++;
      end else begin
        e = rtn_expected.pop_front();
        n_checked++;
        if (e.degenerate) n_degen++;
        if (out_data.rel_pos_radial !== e.rel_pos_radial) begin
          $error("rel_pos_radial exp %h got %h", e.rel_pos_radial, out_data.rel_pos_radial);
          n_fail++;
        end
        if (out_data.rel_pos_along !== e.rel_pos_along) begin
          $error("rel_pos_along exp %h got %h", e.rel_pos_along, out_data.rel_pos_along);
          n_fail++;
        end
        if (out_data.rel_pos_normal !== e.rel_pos_normal) begin
          $error("rel_pos_normal exp %h got %h", e.rel_pos_normal, out_data.rel_pos_normal);
          n_fail++;
        end
        if (out_data.rel_vel_radial !== e.rel_vel_radial) begin
          $error("rel_vel_radial exp %h got %h", e.rel_vel_radial, out_data.rel_vel_radial);
          n_fail++;
        end
        if (out_data.rel_vel_along !== e.rel_vel_along) begin
          $error("rel_vel_along exp %h got %h", e.rel_vel_along, out_data.rel_vel_along);
          n_fail++;
        end
        if (out_data.rel_vel_normal !== e.rel_vel_normal) begin
          $error("rel_vel_normal exp %h got %h", e.rel_vel_normal, out_data.rel_vel_normal);
          n_fail++;
        end
        if (out_data.degenerate !== e.degenerate) begin
          $error("degenerate exp %b got %b", e.degenerate, out_data.degenerate);
          n_fail++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------- stimulus ----------------

  function automatic q_t rand_full();
    return q_t'({$urandom, $urandom});
  endfunction

  // random sign and magnitude of random bit length, sometimes zero
  function automatic q_t rand_scaled();
    q_t v;
    if ($urandom_range(0, 15) == 0) return 0;
    v = rand_full();
    return v >>> (63 - $urandom_range(0, 63));
  endfunction

  function automatic q_t rand_edge();
    case ($urandom_range(0, 4))
      0: return Q_MAX;
      1: return Q_MIN;
      2: return 0;
      3: return 64'sd1;
      default: return -64'sd1;
    endcase
  endfunction

  function automatic irs_in_t rand_state_pair();
    irs_in_t x;
    int kind;
    kind = $urandom_range(0, 9);
    for (int i = 0; i < 12; i++) begin
      q_t v;
      if (kind < 7) v = rand_scaled();
      else if (kind < 9) v = rand_full();
      else v = ($urandom_range(0, 1) != 0) ? rand_edge() : rand_full();
      x[(11 - i) * 64 +: 64] = v;
    end
    // now and then make r and v parallel so h vanishes
    if ($urandom_range(0, 39) == 0) begin
      x.chief_vel_x = x.chief_pos_x;
      x.chief_vel_y = x.chief_pos_y;
      x.chief_vel_z = x.chief_pos_z;
    end
    return x;
  endfunction

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // drive one request, hold until the block takes it
  task automatic send_request(irs_in_t x, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= x;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  typedef struct {
    irs_in_t  x;
    logic     typed;
    irs_out_t e;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic irs_in_t mk(q_t cpx, q_t cpy, q_t cpz, q_t cvx, q_t cvy, q_t cvz,
                                 q_t dpx, q_t dpy, q_t dpz, q_t dvx, q_t dvy, q_t dvz);
    irs_in_t x;
    x = '{cpx, cpy, cpz, cvx, cvy, cvz, dpx, dpy, dpz, dvx, dvy, dvz};
    return x;
  endfunction

  task automatic add_row(irs_in_t x, logic typed);
    dir_row_t r;
    irs_out_t deg;
    deg = '0;
    deg.degenerate = 1'b1;
    r.x = x;
    r.typed = typed;
    r.e = deg;
    dir_rows.push_back(r);
  endtask

  localparam q_t ONE = 64'sh1_0000_0000;

  initial begin
    irs_in_t x;
    n_fail = 0;
    n_checked = 0;
    n_degen = 0;
    cycles = 0;
    use_typed = 1'b0;
    typed_exp = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // degenerate rows: all outputs zero with the flag set
    add_row('0, 1'b1);
    add_row(mk(0, 0, 0, ONE, ONE, ONE, Q_MAX, Q_MIN, ONE, Q_MIN, Q_MAX, 1), 1'b1);
    add_row(mk(ONE, 2*ONE, 3*ONE, 2*ONE, 4*ONE, 6*ONE, 0, 0, 0, 0, 0, 0), 1'b1);
    add_row(mk(ONE, 0, 0, 0, 0, 0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX), 1'b1);
    add_row(mk(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 0, 0, 0, 0, 0, 0), 1'b1);
    add_row(mk(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
               Q_MIN, Q_MIN, Q_MIN), 1'b1);
    // circular orbits, deputy offsets
    add_row(mk(ONE, 0, 0, 0, ONE, 0, ONE, 0, 0, 0, ONE, 0), 1'b0);
    add_row(mk(ONE, 0, 0, 0, ONE, 0, 2*ONE, ONE, ONE, ONE, 0, -ONE), 1'b0);
    add_row(mk(7000*ONE, 0, 0, 0, 7*ONE, 1, 7001*ONE, 5*ONE, -3*ONE, 1, 7*ONE, ONE/2),
            1'b0);
    // saturation corners
    add_row(mk(Q_MAX, 0, 0, 0, Q_MAX, 0, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX), 1'b0);
    add_row(mk(Q_MIN, 0, 0, 0, Q_MIN, 0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN), 1'b0);
    add_row(mk(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 0, 0),
            1'b0);
    add_row(mk(1, 0, 0, 0, 1, 0, -1, -1, -1, -1, -1, -1), 1'b0);
    add_row(mk(1, 1, 0, -1, 1, 0, Q_MAX, 0, 0, 0, 0, Q_MIN), 1'b0);
    add_row(mk(-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, 0, 0, 0, 0, 0), 1'b0);
    add_row(mk(ONE/2, -ONE/3, ONE/5, 1, ONE, -ONE, ONE, ONE, ONE, -ONE, -ONE, -ONE), 1'b0);

    foreach (dir_rows[i]) begin
      use_typed <= dir_rows[i].typed;
      typed_exp <= dir_rows[i].e;
      send_request(dir_rows[i].x, (i % 3 == 2) ? $urandom_range(1, 5) : 0);
    end
    start <= 1'b0;
    use_typed <= 1'b0;

    // let the pipeline drain completely before the random part
    while (rtn_expected.size() != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      x = rand_state_pair();
      send_request(x, rand_gap());
    end
    start <= 1'b0;

    while (rtn_expected.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("checked %0d results, %0d of them degenerate, %0d directed rows",
             n_checked, n_degen, dir_rows.size());
    if (n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", n_fail);
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
design/irs_pkg.sv
design/irs_dot.sv
design/irs_div.sv
design/inertial_to_rtn_relative_state.sv
verif/tb_inertial_to_rtn_relative_state.sv
